/* hw/rtl/calendar_time_counter_macros.svh */
// assertion macros for the calendar time counter
// expects clk and rst_n in the scope of each use
`ifndef CALENDAR_TIME_COUNTER_MACROS_SVH
`define CALENDAR_TIME_COUNTER_MACROS_SVH

// same-cycle implication, off during reset
`define CTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ctc_pkg.sv */
// shared types, constants and calendar functions for the calendar time counter
// no dependencies
package ctc_pkg;

  localparam logic [11:0] YEAR_MIN   = 12'd2020;
  localparam logic [11:0] YEAR_MAX   = 12'd2099;
  localparam logic [11:0] YEAR_SAT   = 12'd4095;
  localparam logic [11:0] YEAR_RESET = 12'd2026;
  // multiples of 100 that fit in the year field
  localparam int CENTURY_CNT = 4095 / 100 + 1;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_SET  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } in_item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        time_valid;
    logic        set_rejected;
  } out_item_t;

  // held calendar time
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_time_t;

  // outcome of one item
  typedef struct packed {
    cal_time_t tm;
    logic      valid;
    logic      rejected;
  } step_res_t;

  // year is a multiple of 100: compare against every century mark
  function automatic logic is_century(input logic [11:0] y);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < CENTURY_CNT; k++) begin
      if (y == 12'(k * 100)) hit = 1'b1;
    end
    return hit;
  endfunction

  // gregorian leap year; a century is divisible by 400 iff it is by 16
  function automatic logic is_leap(input logic [11:0] y);
    logic cent;
    cent = is_century(y);
    return ((y[1:0] == 2'd0) && !cent) || (cent && (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] n;
    unique case (m)
      4'd2:                      n = is_leap(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/calendar_time_counter.sv */
// calendar time counter top level: input register, held time, result register
// depends on ctc_pkg, ctc_next_state and calendar_time_counter_macros.svh
//
//   channel | ports                         | payload
//   in      | in_valid, in_ready, in_data   | ctc_pkg::in_item_t (tick or set)
//   out     | out_valid, out_ready, out_data| ctc_pkg::out_item_t (time and flags)
//
// one item per cycle sustained while out_ready is high; an accepted item is held
// in the input register until it passes through the update logic into the result
// register, whose contents are shown on out
// the update of the held time from one item is a single pass of carry logic
// in_ready drops only when both the input and result registers hold items
// and out_ready is low; reset (rst_n low, synchronous) empties both stages
// and loads 2026-01-01 00:00:00 marked not valid
`include "calendar_time_counter_macros.svh"

module calendar_time_counter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ctc_pkg::out_item_t  out_data
);

  logic               s1_valid_r, s1_valid_nxt;
  ctc_pkg::in_item_t  s1_item_r;
  ctc_pkg::cal_time_t state_r, state_nxt;
  logic               valid_r, valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  ctc_pkg::out_item_t out_r;
  ctc_pkg::step_res_t res;
  logic               s1_adv;
  logic               in_acc;

  // stage handshakes
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // update logic
  ctc_next_state u_next (
    .cur       (state_r),
    .cur_valid (valid_r),
    .item      (s1_item_r),
    .res       (res)
  );

  // next values of control and held time
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (s1_adv) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;

    state_nxt = s1_adv ? res.tm : state_r;
    valid_nxt = s1_adv ? res.valid : valid_r;
  end

  // control and held time registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      valid_r       <= 1'b0;
      state_r.year   <= ctc_pkg::YEAR_RESET;
      state_r.month  <= 4'd1;
      state_r.day    <= 5'd1;
      state_r.hour   <= 5'd0;
      state_r.minute <= 6'd0;
      state_r.second <= 6'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r <= in_data;
    if (s1_adv) begin
      out_r.year         <= res.tm.year;
      out_r.month        <= res.tm.month;
      out_r.day          <= res.tm.day;
      out_r.hour         <= res.tm.hour;
      out_r.minute       <= res.tm.minute;
      out_r.second       <= res.tm.second;
      out_r.time_valid   <= res.valid;
      out_r.set_rejected <= res.rejected;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `CTC_ASSERT_NEXT(a_valid_sticky, valid_r, valid_r, "time valid flag dropped")
  `CTC_ASSERT_NEXT(a_reject_holds, s1_adv && res.rejected, $stable(state_r) && $stable(valid_r), "rejected set changed the held time")
  `CTC_ASSERT_NEXT(a_out_matches, s1_adv, (out_r.second == state_r.second) && (out_r.day == state_r.day) && (out_r.time_valid == valid_r), "result differs from held time")
  `CTC_ASSERT_NOW(a_month_range, out_valid_r, (out_r.month >= 4'd1) && (out_r.month <= 4'd12) && (out_r.hour <= 5'd23), "held month or hour out of range")

endmodule

/* hw/rtl/ctc_next_state.sv */
// next-state logic: tick advance with carries, set check and load
// depends on ctc_pkg
module ctc_next_state (
  input  ctc_pkg::cal_time_t cur,
  input  logic               cur_valid,
  input  ctc_pkg::in_item_t  item,
  output ctc_pkg::step_res_t res
);

  logic [5:0] sec_inc;
  logic [5:0] min_inc;
  logic [4:0] hr_inc;
  logic [5:0] day_inc;
  logic [3:0] mon_inc;
  logic       sec_c, min_c, hr_c, day_c, mon_c;
  logic [4:0] mdays;
  ctc_pkg::cal_time_t adv;
  logic       set_ok;

  // carry chain of one second
  always_comb begin
    sec_inc = cur.second + 6'd1;
    sec_c   = sec_inc >= 6'd60;
    min_inc = cur.minute + {5'd0, sec_c};
    min_c   = min_inc >= 6'd60;
    hr_inc  = cur.hour + {4'd0, min_c};
    hr_c    = hr_inc >= 5'd24;
    day_inc = {1'b0, cur.day} + {5'd0, hr_c};
    mdays   = ctc_pkg::month_days(cur.year, cur.month);
    // a day set beyond the month length rolls over on any tick
    day_c   = day_inc > {1'b0, mdays};
    mon_inc = cur.month + {3'd0, day_c};
    mon_c   = mon_inc > 4'd12;

    adv.second = sec_c ? 6'd0 : sec_inc;
    adv.minute = min_c ? 6'd0 : min_inc;
    adv.hour   = hr_c ? 5'd0 : hr_inc;
    adv.day    = day_c ? 5'd1 : day_inc[4:0];
    adv.month  = mon_c ? 4'd1 : mon_inc;
    // year saturates
    adv.year   = (mon_c && (cur.year != ctc_pkg::YEAR_SAT)) ? cur.year + 12'd1 : cur.year;
  end

  // range check of a set
  assign set_ok = (item.set_year >= ctc_pkg::YEAR_MIN) && (item.set_year <= ctc_pkg::YEAR_MAX)
               && (item.set_month >= 4'd1) && (item.set_month <= 4'd12)
               && (item.set_day >= 5'd1)
               && (item.set_hour <= 5'd23)
               && (item.set_minute <= 6'd59)
               && (item.set_second <= 6'd59);

  // select outcome by item kind
  always_comb begin
    res.tm       = cur;
    res.valid    = cur_valid;
    res.rejected = 1'b0;
    unique case (item.mode)
      ctc_pkg::MODE_TICK: begin
        if (cur_valid) res.tm = adv;
      end
      ctc_pkg::MODE_SET: begin
        if (set_ok) begin
          res.tm.year   = item.set_year;
          res.tm.month  = item.set_month;
          res.tm.day    = item.set_day;
          res.tm.hour   = item.set_hour;
          res.tm.minute = item.set_minute;
          res.tm.second = item.set_second;
          res.valid     = 1'b1;
        end else begin
          res.rejected  = 1'b1;
        end
      end
    endcase
  end

endmodule
